// ----- rtl/core/isoep_pkg.sv -----
// Package: shared codes, constants and calendar tables for the ISO 8601 timestamp parser.
`timescale 1ns / 1ps
package isoep_pkg;

    localparam logic [3:0] ERR_OK           = 4'd0;
    localparam logic [3:0] ERR_FORM         = 4'd1;
    localparam logic [3:0] ERR_DIGIT        = 4'd2;
    localparam logic [3:0] ERR_RANGE        = 4'd3;
    localparam logic [3:0] ERR_EMPTY_FRAC   = 4'd4;
    localparam logic [3:0] ERR_ZONE_RANGE   = 4'd5;
    localparam logic [3:0] ERR_NO_ZONE      = 4'd6;
    localparam logic [3:0] ERR_TRAILING     = 4'd7;
    localparam logic [3:0] ERR_BEFORE_EPOCH = 4'd8;

    localparam logic [2:0] PH_OPEN = 3'd0;
    localparam logic [2:0] PH_FRAC = 3'd1;
    localparam logic [2:0] PH_ZONE = 3'd2;
    localparam logic [2:0] PH_DONE = 3'd3;
    localparam logic [2:0] PH_ERR  = 3'd4;

    localparam logic [4:0] FIXED_LEN = 5'd19;
    localparam logic [4:0] POS_Y_M   = 5'd4;
    localparam logic [4:0] POS_M_D   = 5'd7;
    localparam logic [4:0] POS_T     = 5'd10;
    localparam logic [4:0] POS_H_M   = 5'd13;
    localparam logic [4:0] POS_M_S   = 5'd16;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [14:0] YEAR_SHIFT  = 15'd399;
    localparam logic [15:0] EPOCH_YEAR  = 16'd1970;
    localparam logic [16:0] LEAP_BIAS   = 17'd574;
    localparam logic [10:0] RECIP_25    = 11'd1311;
    localparam int          RECIP_SHIFT = 15;

    localparam logic [9:0] MUL_YEAR = 10'd365;
    localparam logic [9:0] MUL_HOUR = 10'd24;
    localparam logic [9:0] MUL_SIXTY = 10'd60;
    localparam logic [9:0] MUL_MS   = 10'd1000;

    typedef enum logic [7:0] {
        ST_SCAN  = 8'b0000_0001,
        ST_CHECK = 8'b0000_0010,
        ST_DAYS  = 8'b0000_0100,
        ST_HOUR  = 8'b0000_1000,
        ST_MIN   = 8'b0001_0000,
        ST_SEC   = 8'b0010_0000,
        ST_MS    = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    function automatic logic [8:0] cum_days(input logic [6:0] month);
        logic [8:0] r;
        begin
            case (month)
                7'd1: r = 9'd0;
                7'd2: r = 9'd31;
                7'd3: r = 9'd59;
                7'd4: r = 9'd90;
                7'd5: r = 9'd120;
                7'd6: r = 9'd151;
                7'd7: r = 9'd181;
                7'd8: r = 9'd212;
                7'd9: r = 9'd243;
                7'd10: r = 9'd273;
                7'd11: r = 9'd304;
                7'd12: r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
        logic [4:0] r;
        begin
            case (month)
                7'd2: r = leap ? 5'd29 : 5'd28;
                7'd4, 7'd6, 7'd9, 7'd11: r = 5'd30;
                7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/core/iso8601_to_epoch_ms_parser_top.sv -----
// Top level: streaming ISO 8601 timestamp parser giving Unix epoch milliseconds.
//
// Usage: feed one ASCII character per transaction on char_code with in_valid/in_ready;
// mark the final character of a string with is_last. Each string gives one result
// transaction on epoch_ms/error_code with out_valid/out_ready.
// Throughput: one character per cycle while scanning. After the last character the
// block drops in_ready, runs the checks and, on success, makes five passes through the
// shared multiply-accumulate unit (days, hours, minutes, seconds, milliseconds).
// Last it loads the output register; a string that fails a check skips the passes.
// Stall: the result waits in the output register; scanning of the next string
// proceeds meanwhile, and the block holds in the final state only when a second
// result is ready while the first has not been taken.
// Reset: rst_n clears the parser state and the output valid; the block then
// expects the first character of a new string.
// Errors give epoch_ms of zero and the first failing check as error_code.
`timescale 1ns / 1ps
module iso8601_to_epoch_ms_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [47:0] epoch_ms,
    output logic [3:0]  error_code,
    output logic        out_valid,
    input  logic        out_ready
);

    isoep_pkg::state_t state_reg, state_next;

    logic [4:0]  fixed_index_reg, fixed_index_next;
    logic [2:0]  suffix_phase_reg, suffix_phase_next;
    logic [2:0]  suffix_offset_reg, suffix_offset_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [9:0]  milli_reg, milli_next;
    logic [1:0]  frac_digits_reg, frac_digits_next;
    logic        zone_neg_reg, zone_neg_next;
    logic [6:0]  zone_hour_reg, zone_hour_next;
    logic [6:0]  zone_minute_reg, zone_minute_next;
    logic [7:0]  error_flags_reg, error_flags_next;

    logic signed [49:0] acc_reg, acc_next;
    logic signed [16:0] extra_reg, min_add_reg;
    logic [9:0]         milli_pad_reg;
    logic [3:0]         code_reg;

    logic        out_valid_reg;
    logic [47:0] epoch_ms_reg;
    logic [3:0]  error_code_reg;

    logic        in_fire, out_free;
    logic        is_dig;
    logic [3:0]  dig;

    // scan datapath
    always_comb
    begin
        fixed_index_next   = fixed_index_reg;
        suffix_phase_next  = suffix_phase_reg;
        suffix_offset_next = suffix_offset_reg;
        year_next          = year_reg;
        month_next         = month_reg;
        day_next           = day_reg;
        hour_next          = hour_reg;
        minute_next        = minute_reg;
        second_next        = second_reg;
        milli_next         = milli_reg;
        frac_digits_next   = frac_digits_reg;
        zone_neg_next      = zone_neg_reg;
        zone_hour_next     = zone_hour_reg;
        zone_minute_next   = zone_minute_reg;
        error_flags_next   = error_flags_reg;
        is_dig = (char_code >= isoep_pkg::CH_ZERO) && (char_code <= isoep_pkg::CH_NINE);
        dig    = 4'(char_code - isoep_pkg::CH_ZERO);
        if (fixed_index_reg < isoep_pkg::FIXED_LEN)
        begin
            fixed_index_next = fixed_index_reg + 5'd1;
            if (fixed_index_reg == isoep_pkg::POS_Y_M || fixed_index_reg == isoep_pkg::POS_M_D)
            begin
                if (char_code != isoep_pkg::CH_DASH)
                    error_flags_next[0] = 1'b1;
            end
            else if (fixed_index_reg == isoep_pkg::POS_T)
            begin
                if (char_code != isoep_pkg::CH_T)
                    error_flags_next[0] = 1'b1;
            end
            else if (fixed_index_reg == isoep_pkg::POS_H_M
                     || fixed_index_reg == isoep_pkg::POS_M_S)
            begin
                if (char_code != isoep_pkg::CH_COLON)
                    error_flags_next[0] = 1'b1;
            end
            else if (!is_dig)
                error_flags_next[1] = 1'b1;
            else if (fixed_index_reg < isoep_pkg::POS_Y_M)
                year_next = 14'(year_reg * 10 + dig);
            else if (fixed_index_reg < isoep_pkg::POS_M_D)
                month_next = 7'(month_reg * 10 + dig);
            else if (fixed_index_reg < isoep_pkg::POS_T)
                day_next = 7'(day_reg * 10 + dig);
            else if (fixed_index_reg < isoep_pkg::POS_H_M)
                hour_next = 7'(hour_reg * 10 + dig);
            else if (fixed_index_reg < isoep_pkg::POS_M_S)
                minute_next = 7'(minute_reg * 10 + dig);
            else
                second_next = 7'(second_reg * 10 + dig);
        end
        else
        begin
            case (suffix_phase_reg)
                isoep_pkg::PH_OPEN, isoep_pkg::PH_FRAC:
                begin
                    if (suffix_phase_reg == isoep_pkg::PH_OPEN && char_code == isoep_pkg::CH_DOT)
                    begin
                        suffix_phase_next = isoep_pkg::PH_FRAC;
                        frac_digits_next  = 2'd0;
                    end
                    else if (suffix_phase_reg == isoep_pkg::PH_FRAC && is_dig)
                    begin
                        if (frac_digits_reg != 2'd3)
                        begin
                            milli_next       = 10'(milli_reg * 10 + dig);
                            frac_digits_next = frac_digits_reg + 2'd1;
                        end
                    end
                    else if (suffix_phase_reg == isoep_pkg::PH_FRAC && frac_digits_reg == 2'd0)
                    begin
                        error_flags_next[7:4] = isoep_pkg::ERR_EMPTY_FRAC;
                        suffix_phase_next     = isoep_pkg::PH_ERR;
                    end
                    else if (char_code == isoep_pkg::CH_Z)
                        suffix_phase_next = isoep_pkg::PH_DONE;
                    else if (char_code == isoep_pkg::CH_PLUS || char_code == isoep_pkg::CH_DASH)
                    begin
                        suffix_phase_next  = isoep_pkg::PH_ZONE;
                        suffix_offset_next = 3'd0;
                        zone_neg_next      = (char_code == isoep_pkg::CH_DASH);
                    end
                    else
                    begin
                        error_flags_next[7:4] = isoep_pkg::ERR_NO_ZONE;
                        suffix_phase_next     = isoep_pkg::PH_ERR;
                    end
                end
                isoep_pkg::PH_ZONE:
                begin
                    suffix_offset_next = suffix_offset_reg + 3'd1;
                    if (suffix_offset_next == 3'd3)
                    begin
                        if (char_code != isoep_pkg::CH_COLON)
                        begin
                            error_flags_next[7:4] = isoep_pkg::ERR_NO_ZONE;
                            suffix_phase_next     = isoep_pkg::PH_ERR;
                        end
                    end
                    else if (!is_dig)
                        error_flags_next[2] = 1'b1;
                    else if (suffix_offset_next <= 3'd2)
                        zone_hour_next = 7'(zone_hour_reg * 10 + dig);
                    else
                        zone_minute_next = 7'(zone_minute_reg * 10 + dig);
                    if (suffix_offset_next == 3'd5)
                    begin
                        if (error_flags_next[2])
                        begin
                            error_flags_next[7:4] = isoep_pkg::ERR_DIGIT;
                            suffix_phase_next     = isoep_pkg::PH_ERR;
                        end
                        else if (zone_hour_next > 7'd23 || zone_minute_next > 7'd59)
                        begin
                            error_flags_next[7:4] = isoep_pkg::ERR_ZONE_RANGE;
                            suffix_phase_next     = isoep_pkg::PH_ERR;
                        end
                        else
                            suffix_phase_next = isoep_pkg::PH_DONE;
                    end
                end
                isoep_pkg::PH_DONE:
                begin
                    error_flags_next[7:4] = isoep_pkg::ERR_TRAILING;
                    suffix_phase_next     = isoep_pkg::PH_ERR;
                end
                default:
                begin
                end
            endcase
        end
    end

    // calendar checks and day offset
    logic [11:0] yq_in;
    logic [22:0] yq_prod;
    logic [6:0]  y_div100;
    logic [11:0] y_rem25;
    logic        div4, div100, div400, leap;
    logic [14:0] n_shift;
    logic [12:0] n_div4;
    logic [23:0] nq_prod;
    logic [6:0]  n_div100;
    logic [16:0] leaps_n;
    logic        range_bad;
    logic [3:0]  check_code;
    logic [16:0] extra_val;
    logic [12:0] zone_off;
    logic [9:0]  milli_pad;

    always_comb
    begin
        yq_in    = year_reg[13:2];
        yq_prod  = 23'(yq_in * isoep_pkg::RECIP_25);
        y_div100 = 7'(yq_prod >> isoep_pkg::RECIP_SHIFT);
        y_rem25  = 12'(yq_in - 12'(y_div100 * 25));
        div4     = (year_reg[1:0] == 2'd0);
        div100   = div4 && (y_rem25 == 12'd0);
        div400   = div100 && (y_div100[1:0] == 2'd0);
        leap     = (div4 && !div100) || div400;

        n_shift  = {1'b0, year_reg} + isoep_pkg::YEAR_SHIFT;
        n_div4   = n_shift[14:2];
        nq_prod  = 24'(n_div4 * isoep_pkg::RECIP_25);
        n_div100 = 7'(nq_prod >> isoep_pkg::RECIP_SHIFT);
        leaps_n  = 17'(n_div4) - 17'(n_div100) + 17'(n_div100[6:2]);

        extra_val = leaps_n - isoep_pkg::LEAP_BIAS + 17'(isoep_pkg::cum_days(month_reg))
                    + 17'(leap && month_reg > 7'd2) + 17'(day_reg) - 17'd1;

        range_bad = month_reg < 7'd1 || month_reg > 7'd12 || day_reg < 7'd1
                    || day_reg > 7'(isoep_pkg::month_len(month_reg, leap))
                    || hour_reg > 7'd23 || minute_reg > 7'd59 || second_reg > 7'd60;

        if (fixed_index_reg < isoep_pkg::FIXED_LEN || error_flags_reg[0]
            || suffix_phase_reg == isoep_pkg::PH_OPEN)
            check_code = isoep_pkg::ERR_FORM;
        else if (error_flags_reg[1])
            check_code = isoep_pkg::ERR_DIGIT;
        else if (range_bad)
            check_code = isoep_pkg::ERR_RANGE;
        else if (suffix_phase_reg == isoep_pkg::PH_ERR)
            check_code = error_flags_reg[7:4];
        else if (suffix_phase_reg == isoep_pkg::PH_FRAC)
            check_code = (frac_digits_reg == 2'd0) ? isoep_pkg::ERR_EMPTY_FRAC
                                                   : isoep_pkg::ERR_NO_ZONE;
        else if (suffix_phase_reg == isoep_pkg::PH_ZONE)
            check_code = isoep_pkg::ERR_NO_ZONE;
        else
            check_code = isoep_pkg::ERR_OK;

        zone_off = 13'(zone_hour_reg * 60) + 13'(zone_minute_reg);
        case (frac_digits_reg)
            2'd1: milli_pad = 10'(milli_reg * 100);
            2'd2: milli_pad = 10'(milli_reg * 10);
            default: milli_pad = milli_reg;
        endcase
    end

    // shared multiply-accumulate unit
    logic [9:0]         mul_op;
    logic signed [16:0] add_op;
    logic signed [60:0] prod;

    always_comb
    begin
        case (state_reg)
            isoep_pkg::ST_DAYS:
            begin
                mul_op = isoep_pkg::MUL_YEAR;
                add_op = extra_reg;
            end
            isoep_pkg::ST_HOUR:
            begin
                mul_op = isoep_pkg::MUL_HOUR;
                add_op = signed'(17'(hour_reg));
            end
            isoep_pkg::ST_MIN:
            begin
                mul_op = isoep_pkg::MUL_SIXTY;
                add_op = min_add_reg;
            end
            isoep_pkg::ST_SEC:
            begin
                mul_op = isoep_pkg::MUL_SIXTY;
                add_op = signed'(17'(second_reg));
            end
            default:
            begin
                mul_op = isoep_pkg::MUL_MS;
                add_op = signed'(17'(milli_pad_reg));
            end
        endcase
        prod     = acc_reg * signed'({1'b0, mul_op});
        acc_next = prod[49:0] + {{33{add_op[16]}}, add_op};
    end

    assign in_ready = (state_reg == isoep_pkg::ST_SCAN);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isoep_pkg::ST_SCAN:  if (in_fire && is_last) state_next = isoep_pkg::ST_CHECK;
            isoep_pkg::ST_CHECK: state_next = (check_code == isoep_pkg::ERR_OK)
                                              ? isoep_pkg::ST_DAYS : isoep_pkg::ST_DONE;
            isoep_pkg::ST_DAYS:  state_next = isoep_pkg::ST_HOUR;
            isoep_pkg::ST_HOUR:  state_next = isoep_pkg::ST_MIN;
            isoep_pkg::ST_MIN:   state_next = isoep_pkg::ST_SEC;
            isoep_pkg::ST_SEC:   state_next = isoep_pkg::ST_MS;
            isoep_pkg::ST_MS:    state_next = isoep_pkg::ST_DONE;
            isoep_pkg::ST_DONE:  if (out_free) state_next = isoep_pkg::ST_SCAN;
            default:             state_next = isoep_pkg::ST_SCAN;
        endcase
    end

    logic       clear_parse;
    logic [3:0] final_code;

    assign clear_parse = (state_reg == isoep_pkg::ST_DONE) && out_free;
    assign final_code  = (code_reg == isoep_pkg::ERR_OK && acc_reg < 0)
                         ? isoep_pkg::ERR_BEFORE_EPOCH : code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= isoep_pkg::ST_SCAN;
            fixed_index_reg   <= '0;
            suffix_phase_reg  <= isoep_pkg::PH_OPEN;
            suffix_offset_reg <= '0;
            year_reg          <= '0;
            month_reg         <= '0;
            day_reg           <= '0;
            hour_reg          <= '0;
            minute_reg        <= '0;
            second_reg        <= '0;
            milli_reg         <= '0;
            frac_digits_reg   <= '0;
            zone_neg_reg      <= 1'b0;
            zone_hour_reg     <= '0;
            zone_minute_reg   <= '0;
            error_flags_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_parse)
            begin
                fixed_index_reg   <= '0;
                suffix_phase_reg  <= isoep_pkg::PH_OPEN;
                suffix_offset_reg <= '0;
                year_reg          <= '0;
                month_reg         <= '0;
                day_reg           <= '0;
                hour_reg          <= '0;
                minute_reg        <= '0;
                second_reg        <= '0;
                milli_reg         <= '0;
                frac_digits_reg   <= '0;
                zone_neg_reg      <= 1'b0;
                zone_hour_reg     <= '0;
                zone_minute_reg   <= '0;
                error_flags_reg   <= '0;
            end
            else if (in_fire)
            begin
                fixed_index_reg   <= fixed_index_next;
                suffix_phase_reg  <= suffix_phase_next;
                suffix_offset_reg <= suffix_offset_next;
                year_reg          <= year_next;
                month_reg         <= month_next;
                day_reg           <= day_next;
                hour_reg          <= hour_next;
                minute_reg        <= minute_next;
                second_reg        <= second_next;
                milli_reg         <= milli_next;
                frac_digits_reg   <= frac_digits_next;
                zone_neg_reg      <= zone_neg_next;
                zone_hour_reg     <= zone_hour_next;
                zone_minute_reg   <= zone_minute_next;
                error_flags_reg   <= error_flags_next;
            end
            if (clear_parse)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == isoep_pkg::ST_CHECK)
        begin
            code_reg      <= check_code;
            acc_reg       <= 50'(signed'({2'b00, year_reg}) - signed'(isoep_pkg::EPOCH_YEAR));
            extra_reg     <= signed'(extra_val);
            milli_pad_reg <= milli_pad;
            min_add_reg   <= zone_neg_reg ? signed'(17'(minute_reg) + 17'(zone_off))
                                          : signed'(17'(minute_reg) - 17'(zone_off));
        end
        else if (state_reg != isoep_pkg::ST_SCAN && state_reg != isoep_pkg::ST_DONE)
            acc_reg <= acc_next;
        if (clear_parse)
        begin
            error_code_reg <= final_code;
            epoch_ms_reg   <= (final_code == isoep_pkg::ERR_OK) ? acc_reg[47:0] : 48'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign epoch_ms   = epoch_ms_reg;
    assign error_code = error_code_reg;

    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && is_last |=> !in_ready)
        else $error("input accepted during result computation");
    a_err_zero_ms: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != isoep_pkg::ERR_OK |-> epoch_ms == 48'd0)
        else $error("nonzero epoch with error code");
    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fixed_index_reg <= isoep_pkg::FIXED_LEN)
        else $error("fixed index past end of fixed part");

endmodule

// ----- verif/tb_iso8601_to_epoch_ms_parser_top.sv -----
// Testbench: streams timestamp strings into the ISO 8601 parser and checks each epoch result.
`timescale 1ns / 1ps
module tb_iso8601_to_epoch_ms_parser_top;

    typedef struct {
        logic [47:0] ms;
        logic [3:0]  code;
    } stamp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [7:0]  char_code = 8'd0;
    logic        is_last = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [47:0] epoch_ms;
    logic [3:0]  error_code;
    logic        out_valid;
    logic        out_ready = 1'b0;

    stamp_t      stamp_q[$];
    logic [7:0]  line_buf[$];
    int          fail_count = 0;
    int          burst_left = 0;
    bit          calm_send = 1'b0;
    bit          calm_recv = 1'b0;
    int          stall_left = 0;
    int          recv_cycle = 0;

    // parser state mirror
    logic [4:0]  p_index;
    logic [2:0]  p_phase;
    logic [2:0]  p_offset;
    logic [15:0] p_year;
    logic [7:0]  p_month, p_day, p_hour, p_minute, p_second;
    logic [15:0] p_milli;
    logic [7:0]  p_frac;
    logic        p_neg;
    logic [7:0]  p_zh, p_zm;
    logic [7:0]  p_flags;

    iso8601_to_epoch_ms_parser_top u_top (
        .clk(clk), .rst_n(rst_n), .char_code(char_code), .is_last(is_last),
        .in_valid(in_valid), .in_ready(in_ready), .epoch_ms(epoch_ms),
        .error_code(error_code), .out_valid(out_valid), .out_ready(out_ready)
    );

    always #1 clk = ~clk;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= isoep_pkg::CH_ZERO && c <= isoep_pkg::CH_NINE;
    endfunction

    function automatic bit leap_year(input longint y);
        return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
    endfunction

    function automatic longint days_in(input longint y, input int m);
        int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m < 1 || m > 12) return 0;
        if (m == 2 && leap_year(y)) return 29;
        return lens[m - 1];
    endfunction

    function automatic longint leap_count(input longint n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic longint day_number(input longint y, input int m, input longint d);
        longint days;
        days = 365 * (y - 1970) + (leap_count(y + 399) - 97) - leap_count(1969);
        for (int k = 1; k < m && k <= 12; k++) days += days_in(y, k);
        return days + d - 1;
    endfunction

    task automatic clear_parse();
        p_index = '0; p_phase = isoep_pkg::PH_OPEN; p_offset = '0;
        p_year = '0; p_month = '0; p_day = '0; p_hour = '0; p_minute = '0; p_second = '0;
        p_milli = '0; p_frac = '0; p_neg = 1'b0; p_zh = '0; p_zm = '0; p_flags = '0;
    endtask

    task automatic latch_suffix(input logic [3:0] code);
        p_flags = {code, p_flags[3:0]};
        p_phase = isoep_pkg::PH_ERR;
    endtask

    task automatic open_zone(input logic [7:0] c);
        if (c == isoep_pkg::CH_Z) p_phase = isoep_pkg::PH_DONE;
        else if (c == isoep_pkg::CH_PLUS || c == isoep_pkg::CH_DASH)
        begin
            p_phase = isoep_pkg::PH_ZONE;
            p_offset = '0;
            p_neg = (c == isoep_pkg::CH_DASH);
        end
        else latch_suffix(isoep_pkg::ERR_NO_ZONE);
    endtask

    task automatic parse_char(input logic [7:0] c, input bit last);
        stamp_t r;
        logic [7:0] d;
        longint milli, off, secs, total;
        d = c - isoep_pkg::CH_ZERO;
        if (p_index < isoep_pkg::FIXED_LEN)
        begin
            if (p_index == isoep_pkg::POS_Y_M || p_index == isoep_pkg::POS_M_D)
            begin
                if (c != isoep_pkg::CH_DASH) p_flags[0] = 1'b1;
            end
            else if (p_index == isoep_pkg::POS_T)
            begin
                if (c != isoep_pkg::CH_T) p_flags[0] = 1'b1;
            end
            else if (p_index == isoep_pkg::POS_H_M || p_index == isoep_pkg::POS_M_S)
            begin
                if (c != isoep_pkg::CH_COLON) p_flags[0] = 1'b1;
            end
            else if (!is_digit(c)) p_flags[1] = 1'b1;
            else if (p_index < isoep_pkg::POS_Y_M) p_year = 16'(p_year * 10 + d);
            else if (p_index < isoep_pkg::POS_M_D) p_month = 8'(p_month * 10 + d);
            else if (p_index < isoep_pkg::POS_T) p_day = 8'(p_day * 10 + d);
            else if (p_index < isoep_pkg::POS_H_M) p_hour = 8'(p_hour * 10 + d);
            else if (p_index < isoep_pkg::POS_M_S) p_minute = 8'(p_minute * 10 + d);
            else p_second = 8'(p_second * 10 + d);
            p_index++;
        end
        else
        begin
            case (p_phase)
                isoep_pkg::PH_OPEN:
                begin
                    if (c == isoep_pkg::CH_DOT)
                    begin
                        p_phase = isoep_pkg::PH_FRAC;
                        p_frac = '0;
                    end
                    else open_zone(c);
                end
                isoep_pkg::PH_FRAC:
                begin
                    if (is_digit(c))
                    begin
                        if (p_frac < 3)
                        begin
                            p_milli = 16'(p_milli * 10 + d);
                            p_frac++;
                        end
                    end
                    else if (p_frac == 0) latch_suffix(isoep_pkg::ERR_EMPTY_FRAC);
                    else open_zone(c);
                end
                isoep_pkg::PH_ZONE:
                begin
                    p_offset = 3'(p_offset + 1);
                    if (p_offset == 3)
                    begin
                        if (c != isoep_pkg::CH_COLON) latch_suffix(isoep_pkg::ERR_NO_ZONE);
                    end
                    else if (!is_digit(c)) p_flags[2] = 1'b1;
                    else if (p_offset <= 2) p_zh = 8'(p_zh * 10 + d);
                    else p_zm = 8'(p_zm * 10 + d);
                    if (p_phase == isoep_pkg::PH_ZONE && p_offset == 5)
                    begin
                        if (p_flags[2]) latch_suffix(isoep_pkg::ERR_DIGIT);
                        else if (p_zh > 23 || p_zm > 59) latch_suffix(isoep_pkg::ERR_ZONE_RANGE);
                        else p_phase = isoep_pkg::PH_DONE;
                    end
                end
                isoep_pkg::PH_DONE: latch_suffix(isoep_pkg::ERR_TRAILING);
                default: ;
            endcase
        end
        if (!last) return;
        r.ms = 0;
        if (p_index < isoep_pkg::FIXED_LEN || p_flags[0] || p_phase == isoep_pkg::PH_OPEN)
            r.code = isoep_pkg::ERR_FORM;
        else if (p_flags[1]) r.code = isoep_pkg::ERR_DIGIT;
        else if (p_month < 1 || p_month > 12 || p_day < 1
                 || p_day > days_in(p_year, p_month)
                 || p_hour > 23 || p_minute > 59 || p_second > 60) r.code = isoep_pkg::ERR_RANGE;
        else if (p_phase == isoep_pkg::PH_ERR) r.code = p_flags[7:4];
        else if (p_phase == isoep_pkg::PH_FRAC)
            r.code = (p_frac == 0) ? isoep_pkg::ERR_EMPTY_FRAC : isoep_pkg::ERR_NO_ZONE;
        else if (p_phase == isoep_pkg::PH_ZONE) r.code = isoep_pkg::ERR_NO_ZONE;
        else
        begin
            milli = p_milli;
            if (p_frac == 1) milli *= 100;
            else if (p_frac == 2) milli *= 10;
            off = longint'(p_zh) * 60 + p_zm;
            if (p_neg) off = -off;
            secs = day_number(p_year, p_month, p_day) * 86400 + longint'(p_hour) * 3600
                 + longint'(p_minute) * 60 + p_second - off * 60;
            total = secs * 1000 + milli;
            if (total < 0) r.code = isoep_pkg::ERR_BEFORE_EPOCH;
            else
            begin
                r.code = isoep_pkg::ERR_OK;
                r.ms = total[47:0];
            end
        end
        stamp_q.push_back(r);
        clear_parse();
    endtask

    task automatic send_char(input logic [7:0] c, input bit last);
        if (!calm_send && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0) burst_left--;
        in_valid <= 1'b1;
        char_code <= c;
        is_last <= last;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        parse_char(c, last);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
    endtask

    task automatic load_line(input string s);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic wait_drained();
        idle_input();
        while (stamp_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic make_stamp();
        int y, mo, dy, h, mi, s;
        string t;
        y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9999) : $urandom_range(1960, 2200);
        mo = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        dy = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
        h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
        mi = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
        s = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
        t = $sformatf("%04d-%02d-%02dT%02d:%02d:%02d", y, mo, dy, h, mi, s);
        if ($urandom_range(0, 1))
        begin
            t = {t, "."};
            repeat ($urandom_range(1, 5)) t = {t, $sformatf("%0d", $urandom_range(0, 9))};
        end
        case ($urandom_range(0, 2))
            0: t = {t, "Z"};
            1: t = {t, $sformatf("+%02d:%02d", $urandom_range(0, 25), $urandom_range(0, 62))};
            default: t = {t, $sformatf("-%02d:%02d", $urandom_range(0, 23),
                                       $urandom_range(0, 59))};
        endcase
        load_line(t);
    endtask

    task automatic test_directed();
        string cases[$];
        cases = '{"1970-01-01T00:00:00Z", "9999-12-31T23:59:60.999-23:59",
                  "2000-02-29T12:00:00.5+01:30", "1900-02-29T00:00:00Z",
                  "1969-12-31T23:59:59.999Z", "1970-01-01T00:00:00+00:01",
                  "2021-06-15T08:30:00.", "2021-06-15T08:30:00.12",
                  "2021-06-15T08:30:00+0a:00", "2021-06-15T08:30:00+01-00",
                  "2021-06-15T08:30:00+24:00", "2021-06-15T08:30:00ZZ",
                  "2021-06-15T08:30", "2021-06-15X08:30:00Z", "2021-06-15T08:30:00",
                  "2021-13-15T08:30:00Z", "20a1-06-15T08:30:00Z", "2021-06-15T08:30:00+01",
                  "2021-06-15T08:30:00.1234567Z", "2021-06-15T08:30:00Q"};
        foreach (cases[i])
        begin
            load_line(cases[i]);
            send_line();
        end
        load_line("2021-06-15T08:30:00Z");
        line_buf[2] = 8'h00;
        line_buf[19] = 8'hFF;
        send_line();
        wait_drained();
    endtask

    task automatic test_well_formed();
        repeat (12)
        begin
            make_stamp();
            send_line();
        end
    endtask

    task automatic test_mutated();
        int k;
        repeat (10)
        begin
            make_stamp();
            k = $urandom_range(0, line_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: line_buf[k] = 8'($urandom_range(0, 255));
                1: while (line_buf.size() > k + 1) void'(line_buf.pop_back());
                default: repeat ($urandom_range(1, 3))
                    line_buf.push_back(8'($urandom_range(0, 255)));
            endcase
            send_line();
        end
        wait_drained();
    endtask

    task automatic test_noise();
        repeat (10)
        begin
            line_buf.delete();
            repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
            send_line();
        end
    endtask

    always @(posedge clk)
    begin
        recv_cycle <= recv_cycle + 1;
        if (recv_cycle % 300 == 0) calm_recv <= ~calm_recv;
        if (calm_recv) out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 49) == 0)
        begin
            stall_left <= $urandom_range(5, 30);
            out_ready <= 1'b0;
        end
        else out_ready <= (recv_cycle % 5 != 2);
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (stamp_q.size() == 0)
            begin
                $display("%0t: unexpected result ms=%0d code=%0d", $time, epoch_ms, error_code);
                fail_count++;
            end
            else
            begin
                if (epoch_ms !== stamp_q[0].ms)
                begin
                    $display("%0t: epoch_ms expected %0d actual %0d", $time,
                             stamp_q[0].ms, epoch_ms);
                    fail_count++;
                end
                if (error_code !== stamp_q[0].code)
                begin
                    $display("%0t: error_code expected %0d actual %0d", $time,
                             stamp_q[0].code, error_code);
                    fail_count++;
                end
                void'(stamp_q.pop_front());
            end
        end
    end

    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        clear_parse();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        calm_send = 1'b1;
        test_directed();
        calm_send = 1'b0;
        test_well_formed();
        test_mutated();
        test_noise();
        calm_send = 1'b1;
        test_well_formed();
        calm_send = 1'b0;
        test_mutated();
        test_well_formed();
        idle_input();
        wait_cycles = 0;
        while (stamp_q.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && stamp_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
